FILE: rtl/sce_pkg.sv
// Shared constants, codes, request structures and helpers for the saturating execute core.
package sce_pkg;

  localparam int RegCount = 8;
  localparam int MemDepth = 64;

  localparam int CmdW     = 4;
  localparam int RegIdxW  = 3;
  localparam int AddrW    = 8;
  localparam int DataW    = 8;
  localparam int ImmW     = 16;
  localparam int RawW     = 16;

  localparam int RfAw     = (RegCount > 1) ? $clog2(RegCount) : 1;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int AluSteps = DataW;
  localparam int AluCntW  = $clog2(AluSteps);

  localparam logic [DataW-1:0] SatMax = 8'h7f;
  localparam logic [DataW-1:0] SatMin = 8'h80;

  typedef enum logic [CmdW-1:0] {
    CMD_MOV_IMM = 4'd0,
    CMD_MOV_REG = 4'd1,
    CMD_MOV_IND = 4'd2,
    CMD_ADD     = 4'd3,
    CMD_SUB     = 4'd4,
    CMD_MUL     = 4'd5,
    CMD_DIV     = 4'd6,
    CMD_INC     = 4'd7,
    CMD_DEC     = 4'd8,
    CMD_LOAD    = 4'd9,
    CMD_STORE   = 4'd10,
    CMD_ROL     = 4'd11,
    CMD_ROR     = 4'd12,
    CMD_SHL     = 4'd13,
    CMD_SHR     = 4'd14,
    CMD_DISPLAY = 4'd15
  } cmd_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic                    start;
    alu_op_e                 op;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [RegIdxW-1:0] rd_addr_a;
    logic [RegIdxW-1:0] rd_addr_b;
    logic               we;
    logic [RegIdxW-1:0] wr_addr;
    logic [DataW-1:0]   wr_data;
  } rf_req_t;

  typedef struct packed {
    logic             rd_en;
    logic             rd_zero;
    logic [AddrW-1:0] rd_addr;
    logic             we;
    logic [AddrW-1:0] wr_addr;
    logic [DataW-1:0] wr_data;
  } mem_req_t;

  function automatic logic signed [RawW-1:0] sext8(logic [DataW-1:0] v);
    return {{(RawW-DataW){v[DataW-1]}}, v};
  endfunction

endpackage

FILE: rtl/saturating_8bit_cpu_execute_core.sv
// Top level of the saturating 8-bit execute core: sequencer, result logic and output register.
// Moves, loads, stores, rotates, shifts right, displays and a divide by zero bypass the arithmetic
//   unit; add, subtract, increment, decrement and shift left make a single add or subtract, and
//   multiply and divide run eight steps and a sign fix on the shared adder.
// One instruction is in flight at a time; a waiting result holds the next one at commit.
// Reset: asynchronous, active low; registers, memory, flags and program counter read as zero.
module saturating_8bit_cpu_execute_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sce_pkg::CmdW-1:0]           command_i,
  input  logic [sce_pkg::RegIdxW-1:0]        dest_reg_i,
  input  logic [sce_pkg::RegIdxW-1:0]        src_reg_i,
  input  logic signed [sce_pkg::ImmW-1:0]    immediate_i,
  input  logic [sce_pkg::AddrW-1:0]          mem_address_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sce_pkg::DataW-1:0]   shown_value_o,
  output logic [sce_pkg::AddrW-1:0]          pc_after_o,
  output logic                               overflow_flag_o,
  output logic                               underflow_flag_o,
  output logic                               carry_flag_o,
  output logic                               zero_flag_o,
  output logic                               divide_skipped_o
);
  import sce_pkg::*;

  // The sequencer walks through three states. IDLE waits for an input transaction and issues
  // the register file reads. READ has both operands, issues the data memory read and starts
  // the arithmetic unit when the command needs it. EXEC waits for the unit, then commits the
  // instruction once the output register is free or being emptied in the same cycle.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e                  state_q, state_d;

  cmd_e                    cmd_q;
  logic [RegIdxW-1:0]      dst_q;
  logic signed [ImmW-1:0]  imm_q;
  logic [AddrW-1:0]        maddr_q;

  logic [AddrW-1:0]        pc_q;
  logic                    of_q, uf_q, cf_q, zf_q;
  logic                    out_valid_q;
  logic [DataW-1:0]        shown_q;
  logic                    skip_q;

  rf_req_t                 rf_req;
  mem_req_t                mem_req;
  alu_req_t                alu_req;
  logic [DataW-1:0]        rf_rd_a, rf_rd_b, mem_rd;
  logic                    alu_busy;
  logic signed [RawW-1:0]  alu_res;

  logic signed [DataW-1:0] d_val, s_val;
  logic                    accept, commit;
  logic signed [RawW-1:0]  raw;
  logic                    write_dest, flags_upd, skip;
  logic                    in_byte;
  logic [DataW-1:0]        sat_val, shown_val;
  logic                    raw_of, raw_uf, raw_zf;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign commit     = (state_q == ST_EXEC) && !alu_busy && (!out_valid_q || out_ready_i);

  // The register file holds the operand pair from the acceptance read until the next one.
  assign d_val = rf_rd_a;
  assign s_val = rf_rd_b;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The decoded instruction is held for the whole transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      dst_q   <= dest_reg_i;
      imm_q   <= immediate_i;
      maddr_q <= mem_address_i;
    end
  end

  // Register file: both operands are read on acceptance; the destination is written at commit.
  always_comb begin
    rf_req           = '0;
    rf_req.rd_en     = accept;
    rf_req.rd_addr_a = dest_reg_i;
    rf_req.rd_addr_b = src_reg_i;
    rf_req.we        = commit && write_dest;
    rf_req.wr_addr   = dst_q;
    rf_req.wr_data   = sat_val;
  end

  // Data memory: the indirect move takes its address from the source register, and a negative
  // address reads as zero. Loads and stores use the direct address.
  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = (state_q == ST_READ);
    mem_req.rd_zero = (cmd_q == CMD_MOV_IND) && s_val[DataW-1];
    mem_req.rd_addr = (cmd_q == CMD_MOV_IND) ? AddrW'(unsigned'(s_val)) : maddr_q;
    mem_req.we      = commit && (cmd_q == CMD_STORE);
    mem_req.wr_addr = maddr_q;
    mem_req.wr_data = s_val;
  end

  // Arithmetic requests. Increment and decrement add or subtract one, shift left adds the
  // register to itself, and a divide by zero never reaches the unit.
  always_comb begin
    alu_req       = '0;
    alu_req.op    = ALU_ADD;
    alu_req.a     = d_val;
    alu_req.b     = s_val;
    case (cmd_q)
      CMD_ADD: begin
        alu_req.start = 1'b1;
      end
      CMD_SUB: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_SUB;
      end
      CMD_MUL: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
      end
      CMD_DIV: begin
        alu_req.start = (s_val != '0);
        alu_req.op    = ALU_DIV;
      end
      CMD_INC: begin
        alu_req.start = 1'b1;
        alu_req.b     = DataW'(1);
      end
      CMD_DEC: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_SUB;
        alu_req.b     = DataW'(1);
      end
      CMD_SHL: begin
        alu_req.start = 1'b1;
        alu_req.b     = d_val;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
    alu_req.start = alu_req.start && (state_q == ST_READ);
  end

  sce_rf u_rf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rf_req),
    .rd_a_o (rf_rd_a),
    .rd_b_o (rf_rd_b)
  );

  sce_dmem u_dmem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rd_o   (mem_rd)
  );

  sce_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .busy_o   (alu_busy),
    .result_o (alu_res)
  );

  // Raw result at full precision. Stores, displays and a skipped divide leave the destination
  // alone; displays and a skipped divide also leave the flags alone.
  always_comb begin
    raw        = '0;
    write_dest = 1'b1;
    flags_upd  = 1'b1;
    skip       = 1'b0;
    case (cmd_q)
      CMD_MOV_IMM: raw = imm_q;
      CMD_MOV_REG: raw = sext8(s_val);
      CMD_MOV_IND: raw = sext8(mem_rd);
      CMD_LOAD:    raw = sext8(mem_rd);
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_INC, CMD_DEC, CMD_SHL: begin
        raw = alu_res;
      end
      CMD_DIV: begin
        if (s_val == '0) begin
          skip       = 1'b1;
          write_dest = 1'b0;
          flags_upd  = 1'b0;
          raw        = sext8(d_val);
        end else begin
          raw = alu_res;
        end
      end
      CMD_STORE: begin
        write_dest = 1'b0;
        raw        = sext8(s_val);
      end
      CMD_ROL: raw = sext8({d_val[DataW-2:0], d_val[DataW-1]});
      CMD_ROR: raw = sext8({d_val[0], d_val[DataW-1:1]});
      CMD_SHR: raw = sext8({d_val[DataW-1], d_val[DataW-1:1]});
      default: begin
        write_dest = 1'b0;
        flags_upd  = 1'b0;
        raw        = sext8(s_val);
      end
    endcase
  end

  // The raw value fits a byte exactly when its upper bits all match the byte's sign bit.
  assign in_byte   = (raw[RawW-1:DataW-1] == '0) || (raw[RawW-1:DataW-1] == '1);
  assign raw_of    = !raw[RawW-1] && !in_byte;
  assign raw_uf    = raw[RawW-1] && !in_byte;
  assign raw_zf    = (raw == '0);
  assign sat_val   = in_byte ? raw[DataW-1:0] : (raw[RawW-1] ? SatMin : SatMax);
  assign shown_val = write_dest ? sat_val : raw[DataW-1:0];

  // Architectural state that doubles as the visible part of the result: the program counter and
  // the flags only change when a result is loaded into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      of_q        <= 1'b0;
      uf_q        <= 1'b0;
      cf_q        <= 1'b0;
      zf_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        pc_q        <= pc_q + AddrW'(1);
        out_valid_q <= 1'b1;
        if (flags_upd) begin
          of_q <= raw_of;
          uf_q <= raw_uf;
          cf_q <= raw_of || raw_uf;
          zf_q <= raw_zf;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      shown_q <= shown_val;
      skip_q  <= skip;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign shown_value_o    = shown_q;
  assign pc_after_o       = pc_q;
  assign overflow_flag_o  = of_q;
  assign underflow_flag_o = uf_q;
  assign carry_flag_o     = cf_q;
  assign zero_flag_o      = zf_q;
  assign divide_skipped_o = skip_q;

endmodule

FILE: rtl/sce_rf.sv
// Register file with two registered read ports, one write port and per-entry valid bits.
module sce_rf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sce_pkg::rf_req_t       req_i,
  output logic [sce_pkg::DataW-1:0] rd_a_o,
  output logic [sce_pkg::DataW-1:0] rd_b_o
);
  import sce_pkg::*;

  localparam int ExtW = (RfAw > RegIdxW) ? RfAw : RegIdxW;

  logic [DataW-1:0]    mem_q [RegCount];
  logic [RegCount-1:0] vld_q;
  logic [DataW-1:0]    rd_a_q, rd_b_q;
  logic [ExtW-1:0]     ra_ext, rb_ext, wa_ext;
  logic [RfAw-1:0]     ra, rb, wa;
  logic                ra_ok, rb_ok, wa_ok;

  assign ra_ext = ExtW'(req_i.rd_addr_a);
  assign rb_ext = ExtW'(req_i.rd_addr_b);
  assign wa_ext = ExtW'(req_i.wr_addr);
  assign ra     = ra_ext[RfAw-1:0];
  assign rb     = rb_ext[RfAw-1:0];
  assign wa     = wa_ext[RfAw-1:0];
  assign ra_ok  = int'(ra_ext) < RegCount;
  assign rb_ok  = int'(rb_ext) < RegCount;
  assign wa_ok  = int'(wa_ext) < RegCount;

  // Entries that were never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we && wa_ok) begin
      vld_q[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we && wa_ok) begin
      mem_q[wa] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_a_q <= (ra_ok && vld_q[ra]) ? mem_q[ra] : '0;
      rd_b_q <= (rb_ok && vld_q[rb]) ? mem_q[rb] : '0;
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

FILE: rtl/sce_dmem.sv
// Data memory with one registered read port, one write port and per-entry valid bits.
module sce_dmem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sce_pkg::mem_req_t         req_i,
  output logic [sce_pkg::DataW-1:0] rd_o
);
  import sce_pkg::*;

  logic [DataW-1:0]    mem_q [MemDepth];
  logic [MemDepth-1:0] vld_q;
  logic [DataW-1:0]    rd_q;
  logic [MemAw-1:0]    ra, wa;
  logic                ra_ok, wa_ok;

  assign ra    = req_i.rd_addr[MemAw-1:0];
  assign wa    = req_i.wr_addr[MemAw-1:0];
  assign ra_ok = !req_i.rd_zero && (int'(req_i.rd_addr) < MemDepth);
  assign wa_ok = int'(req_i.wr_addr) < MemDepth;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we && wa_ok) begin
      vld_q[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we && wa_ok) begin
      mem_q[wa] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= (ra_ok && vld_q[ra]) ? mem_q[ra] : '0;
    end
  end

  assign rd_o = rd_q;

endmodule

FILE: rtl/sce_alu.sv
// Iterative arithmetic unit: one shared adder serves add, subtract, shift-add multiply and
// restoring divide.
module sce_alu (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sce_pkg::alu_req_t               req_i,
  output logic                            busy_o,
  output logic signed [sce_pkg::RawW-1:0] result_o
);
  import sce_pkg::*;

  logic                busy_q, busy_d;
  logic                fix_q, fix_d;
  logic [AluCntW-1:0]  cnt_q, cnt_d;
  alu_op_e             op_q, op_d;
  logic                neg_q, neg_d;
  logic [RawW-1:0]     acc_q, acc_d;
  logic [RawW-1:0]     opd_q, opd_d;
  logic [DataW-1:0]    sh_q, sh_d;

  logic [DataW-1:0]    abs_a, abs_b;
  logic [RawW-1:0]     add_x, add_y, add_sum, div_x;
  logic                add_sub;
  logic                last;

  assign abs_a = req_i.a[DataW-1] ? DataW'(-req_i.a) : DataW'(req_i.a);
  assign abs_b = req_i.b[DataW-1] ? DataW'(-req_i.b) : DataW'(req_i.b);
  assign div_x = {acc_q[RawW-2:0], sh_q[DataW-1]};
  assign last  = (cnt_q == AluCntW'(AluSteps - 1));

  // The one adder of the unit.
  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + RawW'(add_sub);

  always_comb begin
    busy_d  = busy_q;
    fix_d   = fix_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    opd_d   = opd_q;
    sh_d    = sh_q;
    add_x   = acc_q;
    add_y   = opd_q;
    add_sub = 1'b0;

    if (req_i.start) begin
      busy_d = 1'b1;
      fix_d  = 1'b0;
      cnt_d  = '0;
      op_d   = req_i.op;
      neg_d  = req_i.a[DataW-1] ^ req_i.b[DataW-1];
      case (req_i.op)
        ALU_MUL: begin
          acc_d = '0;
          opd_d = RawW'(abs_a);
          sh_d  = abs_b;
        end
        ALU_DIV: begin
          acc_d = '0;
          opd_d = RawW'(abs_b);
          sh_d  = abs_a;
        end
        default: begin
          acc_d = sext8(req_i.a);
          opd_d = sext8(req_i.b);
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        ALU_ADD: begin
          acc_d  = add_sum;
          busy_d = 1'b0;
        end
        ALU_SUB: begin
          add_sub = 1'b1;
          acc_d   = add_sum;
          busy_d  = 1'b0;
        end
        ALU_MUL: begin
          if (fix_q) begin
            add_x   = '0;
            add_y   = acc_q;
            add_sub = neg_q;
            acc_d   = add_sum;
            busy_d  = 1'b0;
          end else begin
            if (sh_q[0]) begin
              acc_d = add_sum;
            end
            opd_d = opd_q << 1;
            sh_d  = sh_q >> 1;
            cnt_d = cnt_q + AluCntW'(1);
            if (last) begin
              fix_d = 1'b1;
            end
          end
        end
        ALU_DIV: begin
          if (fix_q) begin
            add_x   = '0;
            add_y   = RawW'(sh_q);
            add_sub = neg_q;
            acc_d   = add_sum;
            busy_d  = 1'b0;
          end else begin
            add_x   = div_x;
            add_sub = 1'b1;
            acc_d   = add_sum[RawW-1] ? div_x : add_sum;
            sh_d    = {sh_q[DataW-2:0], ~add_sum[RawW-1]};
            cnt_d   = cnt_q + AluCntW'(1);
            if (last) begin
              fix_d = 1'b1;
            end
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_ADD;
    end else begin
      busy_q <= busy_d;
      fix_q  <= fix_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    acc_q <= acc_d;
    opd_q <= opd_d;
    sh_q  <= sh_d;
  end

  assign busy_o   = busy_q;
  assign result_o = acc_q;

endmodule

FILE: rtl/sce_checker.sv
// Port-level checker for the saturating execute core, bound to the top level.
module sce_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [sce_pkg::CmdW-1:0]           command_i,
  input logic [sce_pkg::RegIdxW-1:0]        dest_reg_i,
  input logic [sce_pkg::RegIdxW-1:0]        src_reg_i,
  input logic signed [sce_pkg::ImmW-1:0]    immediate_i,
  input logic [sce_pkg::AddrW-1:0]          mem_address_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [sce_pkg::DataW-1:0]   shown_value_o,
  input logic [sce_pkg::AddrW-1:0]          pc_after_o,
  input logic                               overflow_flag_o,
  input logic                               underflow_flag_o,
  input logic                               carry_flag_o,
  input logic                               zero_flag_o,
  input logic                               divide_skipped_o
);
  import sce_pkg::*;

  // An offered instruction stays offered, unchanged, until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(command_i) && $stable(dest_reg_i) &&
    $stable(src_reg_i) && $stable(immediate_i) && $stable(mem_address_i))
    else $error("offered instruction changed before it was taken");

  // A stalled result holds its value and stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(shown_value_o) &&
    $stable(pc_after_o) && $stable(divide_skipped_o))
    else $error("stalled result changed");

  // Only one instruction is in flight: no new transaction right after one is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an instruction is in flight");

  // The program counter only moves with a new result, and then by exactly one.
  a_pc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_after_o != $past(pc_after_o) |-> out_valid_o && (pc_after_o == $past(pc_after_o) + 8'd1))
    else $error("program counter moved without a result or by more than one");

  // Carry is the union of overflow and underflow, which exclude each other and a zero result.
  a_flag_consistency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (carry_flag_o == (overflow_flag_o || underflow_flag_o)) &&
    !(overflow_flag_o && underflow_flag_o) && !(zero_flag_o && carry_flag_o))
    else $error("inconsistent status flags");

endmodule

bind saturating_8bit_cpu_execute_core sce_checker u_sce_checker (.*);
